// ===== rtl/core/baif_pkg.sv =====
// shared types, constants and helpers for the baro/inertial altitude fuser
`timescale 1ns / 1ps
package baif_pkg;

  // register map
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_POS_GAIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPD_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SPD_GATE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOST_LIM = 3'd4;

  // register reset values
  localparam logic [15:0]        POS_GAIN_RST = 16'd328;
  localparam logic [15:0]        SPD_GAIN_RST = 16'd6554;
  localparam logic signed [31:0] SPD_GATE_RST = 32'sd65536;
  localparam logic [15:0]        TIMEOUT_RST  = 16'd600;
  localparam logic [3:0]         LOST_LIM_RST = 4'd10;

  // two pi in q16.16
  localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;

  // restoring divider: 33-bit magnitude shifted up by 16
  localparam int unsigned DivSteps = 49;
  localparam int unsigned DivCntW  = 6;

  localparam logic [3:0] LOST_MAX = 4'd15;

  typedef struct packed {
    logic               func;
    logic               sample_ready;
    logic [23:0]        alt_raw;
    logic signed [31:0] speed_in;
    logic [15:0]        dt;
    logic [31:0]        tick_now;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic signed [31:0] speed_out;
    logic signed [31:0] baro_altitude;
    logic               start_conversion;
    logic               sensor_healthy;
    logic [3:0]         lost_samples;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EVAL,
    CMD_MUL_TRAP,
    CMD_ADD_TRAP,
    CMD_MUL_PC1,
    CMD_MUL_C2,
    CMD_MUL_PULL,
    CMD_ADD_PULL,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_END,
    CMD_MUL_SC1,
    CMD_MUL_CORR,
    CMD_ADD_CORR,
    CMD_COMMIT,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic fuse;
    logic div_last;
    logic gate;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EVAL,
    S_TRAP_M,
    S_TRAP_A,
    S_PC1,
    S_PC2,
    S_PULL_M,
    S_PULL_A,
    S_DIV_I,
    S_DIV,
    S_DIV_E,
    S_SC1,
    S_SC2,
    S_CORR_M,
    S_CORR_A,
    S_COMMIT,
    S_DONE
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/baif_ctrl.sv =====
// sequencer for the fuser datapath
`timescale 1ns / 1ps
module baif_ctrl
  import baif_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_e  cmd
);

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == CMD_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd        = CMD_EVAL;
        state_next = stat.fuse ? S_TRAP_M : S_DONE;
      end
      S_TRAP_M: begin
        cmd        = CMD_MUL_TRAP;
        state_next = S_TRAP_A;
      end
      S_TRAP_A: begin
        cmd        = CMD_ADD_TRAP;
        state_next = S_PC1;
      end
      S_PC1: begin
        cmd        = CMD_MUL_PC1;
        state_next = S_PC2;
      end
      S_PC2: begin
        cmd        = CMD_MUL_C2;
        state_next = S_PULL_M;
      end
      S_PULL_M: begin
        cmd        = CMD_MUL_PULL;
        state_next = S_PULL_A;
      end
      S_PULL_A: begin
        cmd        = CMD_ADD_PULL;
        state_next = S_DIV_I;
      end
      S_DIV_I: begin
        cmd        = CMD_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd = CMD_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_DIV_E;
        end
      end
      S_DIV_E: begin
        cmd        = CMD_DIV_END;
        state_next = S_SC1;
      end
      S_SC1: begin
        if (stat.gate) begin
          cmd        = CMD_MUL_SC1;
          state_next = S_SC2;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_SC2: begin
        cmd        = CMD_MUL_C2;
        state_next = S_CORR_M;
      end
      S_CORR_M: begin
        cmd        = CMD_MUL_CORR;
        state_next = S_CORR_A;
      end
      S_CORR_A: begin
        cmd        = CMD_ADD_CORR;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd        = CMD_COMMIT;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd        = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/baif_dp.sv =====
// fuser datapath: registers, state, shared multiplier and serial divider
`timescale 1ns / 1ps
module baif_dp
  import baif_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  in_item_t           in_data,
  input  cmd_e               cmd,
  output stat_t              stat,
  output out_item_t          out_data
);

  logic [15:0]        pos_gain, spd_gain, tmo;
  logic signed [31:0] spd_gate;
  logic [3:0]         lost_lim;

  in_item_t           in_q;
  logic signed [31:0] position, prev_speed, prev_pos, altitude, alt_off;
  logic [31:0]        stamp [2];
  logic [3:0]         lost_cnt;
  logic               healthy;

  logic signed [31:0] speed_res, derived;
  logic               start_q, gate_q, neg_q, nz_q;
  logic signed [54:0] prod;
  logic [48:0]        quo;
  logic [16:0]        rem;
  logic [DivCntW-1:0] dcnt;

  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] prod_r16, prod_r17;
  logic signed [31:0] alt_q;
  logic signed [33:0] pos_diff;
  logic [33:0]        pos_mag;
  logic [17:0]        rem_sh;
  logic [17:0]        rem_sub;
  logic signed [31:0] derived_next;
  logic               timed_out;
  logic [3:0]         lost_inc;

  assign prod_r16 = (prod + 55'sd32768) >>> 16;
  assign prod_r17 = (prod + 55'sd65536) >>> 17;
  assign alt_q    = {in_q.alt_raw, 8'h00};
  assign pos_diff = {{2{position[31]}}, position} - {{2{prev_pos[31]}}, prev_pos};
  assign pos_mag  = pos_diff[33] ? -pos_diff : pos_diff;
  assign rem_sh   = {rem, quo[48]};
  assign rem_sub  = rem_sh - {2'b00, in_q.dt};
  assign timed_out = (in_q.tick_now - stamp[in_q.func]) > {16'h0000, tmo};
  assign lost_inc  = (lost_cnt < LOST_MAX) ? lost_cnt + 4'd1 : lost_cnt;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      CMD_MUL_TRAP: begin
        mul_a = {{2{prev_speed[31]}}, prev_speed} + {{2{in_q.speed_in[31]}}, in_q.speed_in};
        mul_b = {5'b0, in_q.dt};
      end
      CMD_MUL_PC1: begin
        mul_a = {18'b0, in_q.dt};
        mul_b = {5'b0, pos_gain};
      end
      CMD_MUL_SC1: begin
        mul_a = {18'b0, in_q.dt};
        mul_b = {5'b0, spd_gain};
      end
      CMD_MUL_C2: begin
        mul_a = prod_r16[33:0];
        mul_b = TWO_PI_Q16;
      end
      CMD_MUL_PULL: begin
        mul_a = {{2{altitude[31]}}, altitude} - {{2{position[31]}}, position};
        mul_b = prod_r16[20:0];
      end
      CMD_MUL_CORR: begin
        mul_a = {{2{derived[31]}}, derived} - {{2{in_q.speed_in[31]}}, in_q.speed_in};
        mul_b = prod_r16[20:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quotient to saturated signed speed
  always_comb begin
    if (in_q.dt == 16'h0000) begin
      derived_next = neg_q ? 32'sh80000000 : (nz_q ? 32'sh7FFFFFFF : 32'sh0);
    end else if (neg_q) begin
      derived_next = (quo > 49'd2147483648) ? 32'sh80000000 : -(quo[31:0]);
    end else begin
      derived_next = (quo > 49'd2147483647) ? 32'sh7FFFFFFF : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain   <= POS_GAIN_RST;
      spd_gain   <= SPD_GAIN_RST;
      spd_gate   <= SPD_GATE_RST;
      tmo        <= TIMEOUT_RST;
      lost_lim   <= LOST_LIM_RST;
      position   <= '0;
      prev_speed <= '0;
      prev_pos   <= '0;
      altitude   <= '0;
      alt_off    <= '0;
      stamp[0]   <= '0;
      stamp[1]   <= '0;
      lost_cnt   <= '0;
      healthy    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POS_GAIN: pos_gain <= cfg_data[15:0];
          REG_SPD_GAIN: spd_gain <= cfg_data[15:0];
          REG_SPD_GATE: spd_gate <= cfg_data;
          REG_TIMEOUT:  tmo      <= cfg_data[15:0];
          REG_LOST_LIM: lost_lim <= cfg_data[3:0];
          default: ;
        endcase
      end
      case (cmd)
        CMD_EVAL: begin
          if (!in_q.func) begin
            if (in_q.sample_ready) begin
              lost_cnt <= '0;
              healthy  <= 1'b1;
              alt_off  <= sat32({{32{alt_q[31]}}, alt_q} - {{32{position[31]}}, position});
              altitude <= position;
              stamp[0] <= in_q.tick_now;
            end else if (timed_out) begin
              if (lost_inc >= lost_lim) begin
                lost_cnt <= lost_lim;
                healthy  <= 1'b0;
              end else begin
                lost_cnt <= lost_inc;
              end
            end
          end else if (in_q.sample_ready) begin
            altitude <= sat32({{32{alt_q[31]}}, alt_q} - {{32{alt_off[31]}}, alt_off});
            stamp[1] <= in_q.tick_now;
          end
        end
        CMD_ADD_TRAP: begin
          position <= sat32({{32{position[31]}}, position} + {{9{prod_r17[54]}}, prod_r17});
        end
        CMD_ADD_PULL: begin
          position <= sat32({{32{position[31]}}, position} + {{9{prod_r16[54]}}, prod_r16});
        end
        CMD_COMMIT: begin
          prev_pos   <= position;
          prev_speed <= speed_res;
        end
        default: ;
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd)
      CMD_LOAD: begin
        in_q <= in_data;
      end
      CMD_EVAL: begin
        speed_res <= in_q.speed_in;
        start_q   <= in_q.sample_ready || timed_out;
      end
      CMD_DIV_INIT: begin
        quo   <= {pos_mag[32:0], 16'h0000};
        rem   <= '0;
        dcnt  <= '0;
        neg_q <= pos_diff[33];
        nz_q  <= (pos_diff != 34'sd0);
      end
      CMD_DIV_STEP: begin
        dcnt <= dcnt + 1'b1;
        if (!rem_sub[17]) begin
          rem <= rem_sub[16:0];
          quo <= {quo[47:0], 1'b1};
        end else begin
          rem <= rem_sh[16:0];
          quo <= {quo[47:0], 1'b0};
        end
      end
      CMD_DIV_END: begin
        derived <= derived_next;
        gate_q  <= (derived_next < spd_gate);
      end
      CMD_ADD_CORR: begin
        speed_res <= sat32({{32{in_q.speed_in[31]}}, in_q.speed_in}
                           + {{9{prod_r16[54]}}, prod_r16});
      end
      CMD_OUT: begin
        out_data.position_out     <= position;
        out_data.speed_out        <= speed_res;
        out_data.baro_altitude    <= altitude;
        out_data.start_conversion <= start_q;
        out_data.sensor_healthy   <= healthy;
        out_data.lost_samples     <= lost_cnt;
      end
      default: ;
    endcase
  end

  assign stat.fuse     = in_q.func;
  assign stat.div_last = (dcnt == DivCntW'(DivSteps - 1));
  assign stat.gate     = gate_q;

endmodule

// ===== rtl/core/baro_inertial_altitude_fuser_unit.sv =====
// top level of the baro/inertial altitude fuser
`timescale 1ns / 1ps
// Complementary filter for vertical position. Each input transaction is one
// tick: in calibrate mode (func 0) it records the barometer offset against the
// held position and tracks sensor health; in fuse mode (func 1) it integrates
// speed trapezoidally, pulls the position toward the barometer and corrects
// speed from the position derivative when that derivative is below the gate.
// Each tick gives exactly one output transaction. A fuse tick takes longer
// than a calibrate tick, and longer still when the speed correction
// applies. The fuse time is set by the 49-step serial divider for the
// derived speed and by the single shared 34x21 multiplier stepping through
// the terms. The next tick can be accepted in the same cycle that output
// valid rises. A finished result sits in an output register, so the next
// tick is accepted while it waits. Configuration writes land at once and
// must only be made while the block is idle.
module baro_inertial_altitude_fuser_unit
  import baif_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  // input ticks
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data
);

  cmd_e  cmd;
  stat_t stat;

  // sequencer
  baif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and filter state
  baif_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // one tick at a time: after an accept the input side closes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a tick is in flight");

  // a new result only comes out of a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced without a tick in work");

  // lost count never reaches its saturation value while the sensor is healthy
  a_healthy_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sensor_healthy) |-> (out_data.lost_samples != LOST_MAX))
    else $error("healthy sensor with saturated lost count");
`endif

endmodule

// ===== verif/baro_inertial_altitude_fuser_unit_test.sv =====
// testbench for the baro/inertial altitude fuser top level
`timescale 1ns / 1ps
module baro_inertial_altitude_fuser_unit_test;
  import baif_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]       cfg_data;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;

  baro_inertial_altitude_fuser_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor copy of the filter registers and state
  logic [15:0]        fz_pos_gain, fz_spd_gain, fz_timeout;
  logic signed [31:0] fz_gate;
  logic [3:0]         fz_lost_lim;
  logic signed [31:0] fz_position, fz_prev_speed, fz_prev_pos, fz_altitude, fz_offset;
  logic [31:0]        fz_stamp [2];
  logic [3:0]         fz_lost;
  logic               fz_healthy;

  out_item_t pending_fusion_results [$];
  int        error_count = 0;
  int        ticks_sent = 0;
  int        results_seen = 0;
  int        calib_seen = 0;
  int        corr_seen = 0;
  int unsigned cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // round to nearest, halves up, by arithmetic shift
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                      input int n);
    logic signed [63:0] y;
    y = x + (64'sd1 <<< (n - 1));
    return y >>> n;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [63:0] gain_coef(input logic [15:0] step,
                                                    input logic [15:0] gain);
    logic signed [63:0] c;
    c = round_shift($signed({32'd0, step}) * $signed({32'd0, gain}), 16);
    return round_shift(c * 64'sd411775, 16);
  endfunction

  function automatic void fuser_reset_state();
    fz_pos_gain = POS_GAIN_RST;
    fz_spd_gain = SPD_GAIN_RST;
    fz_gate     = SPD_GATE_RST;
    fz_timeout  = TIMEOUT_RST;
    fz_lost_lim = LOST_LIM_RST;
    fz_position = '0; fz_prev_speed = '0; fz_prev_pos = '0;
    fz_altitude = '0; fz_offset = '0;
    fz_stamp[0] = '0; fz_stamp[1] = '0;
    fz_lost = '0; fz_healthy = 1'b0;
  endfunction

  // expected result of one tick, advancing the predictor state
  function automatic out_item_t fuse_tick(input in_item_t t);
    out_item_t r;
    logic signed [63:0] alt_q, spd_in, spd_out, diff, derived, c, pos;
    logic [31:0] elapsed;
    logic timed_out, start;
    alt_q   = $signed({{40{t.alt_raw[23]}}, t.alt_raw}) * 64'sd256;
    spd_in  = t.speed_in;
    spd_out = spd_in;
    start   = 1'b0;
    elapsed = t.tick_now - fz_stamp[t.func];
    timed_out = elapsed > {16'd0, fz_timeout};
    if (!t.func) begin
      calib_seen++;
      if (t.sample_ready) begin
        fz_lost = '0;
        fz_healthy = 1'b1;
        fz_offset = 32'(clamp32(alt_q - fz_position));
        fz_altitude = fz_position;
        start = 1'b1;
        fz_stamp[0] = t.tick_now;
      end else if (timed_out) begin
        if (fz_lost < 4'd15) fz_lost = fz_lost + 4'd1;
        if (fz_lost >= fz_lost_lim) begin
          fz_lost = fz_lost_lim;
          fz_healthy = 1'b0;
        end
        start = 1'b1;
      end
    end else begin
      if (t.sample_ready) begin
        fz_altitude = 32'(clamp32(alt_q - fz_offset));
        start = 1'b1;
        fz_stamp[1] = t.tick_now;
      end else if (timed_out) begin
        start = 1'b1;
      end
      pos = clamp32(fz_position + round_shift(
              (fz_prev_speed + spd_in) * $signed({48'd0, t.dt}), 17));
      c = gain_coef(t.dt, fz_pos_gain);
      pos = clamp32(pos + round_shift((fz_altitude - pos) * c, 16));
      fz_position = pos[31:0];
      diff = pos - fz_prev_pos;
      if (t.dt == 0)
        derived = (diff > 0) ? 64'sd2147483647 : ((diff < 0) ? -64'sd2147483648 : 64'sd0);
      else
        derived = clamp32((diff * 64'sd65536) / $signed({48'd0, t.dt}));
      if (derived < fz_gate) begin
        corr_seen++;
        c = gain_coef(t.dt, fz_spd_gain);
        spd_out = clamp32(spd_in + round_shift((derived - spd_in) * c, 16));
      end
      fz_prev_pos = fz_position;
      fz_prev_speed = spd_out[31:0];
    end
    r.position_out     = fz_position;
    r.speed_out        = spd_out[31:0];
    r.baro_altitude    = fz_altitude;
    r.start_conversion = start;
    r.sensor_healthy   = fz_healthy;
    r.lost_samples     = fz_lost;
    return r;
  endfunction

  // directed table: expected result typed only where obvious
  typedef struct {
    in_item_t  tick;
    logic      has_fixed;
    out_item_t fixed;
  } directed_row_t;
  directed_row_t directed_rows [$];

  function automatic in_item_t mk(input logic f, input logic rdy, input logic [23:0] alt,
                                  input logic [31:0] spd, input logic [15:0] step,
                                  input logic [31:0] now);
    in_item_t t;
    t.func = f; t.sample_ready = rdy; t.alt_raw = alt;
    t.speed_in = spd; t.dt = step; t.tick_now = now;
    return t;
  endfunction

  function automatic void add_row(input in_item_t t);
    directed_row_t d;
    d.tick = t; d.has_fixed = 1'b0; d.fixed = '0;
    directed_rows.push_back(d);
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_fusion_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        error_count++;
      end else begin
        e = pending_fusion_results.pop_front();
        if (out_data.position_out !== e.position_out) begin
          $error("position_out exp %0d got %0d", e.position_out, out_data.position_out);
          error_count++;
        end
        if (out_data.speed_out !== e.speed_out) begin
          $error("speed_out exp %0d got %0d", e.speed_out, out_data.speed_out);
          error_count++;
        end
        if (out_data.baro_altitude !== e.baro_altitude) begin
          $error("baro_altitude exp %0d got %0d", e.baro_altitude, out_data.baro_altitude);
          error_count++;
        end
        if (out_data.start_conversion !== e.start_conversion) begin
          $error("start_conversion exp %0b got %0b", e.start_conversion,
                 out_data.start_conversion);
          error_count++;
        end
        if (out_data.sensor_healthy !== e.sensor_healthy) begin
          $error("sensor_healthy exp %0b got %0b", e.sensor_healthy, out_data.sensor_healthy);
          error_count++;
        end
        if (out_data.lost_samples !== e.lost_samples) begin
          $error("lost_samples exp %0d got %0d", e.lost_samples, out_data.lost_samples);
          error_count++;
        end
      end
    end
  end

  // receiver stall generator
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // send one transaction, expectation queued at acceptance
  task automatic send_tick(input in_item_t t, input logic has_fixed, input out_item_t fixed);
    out_item_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = fuse_tick(t);
    if (has_fixed && e !== fixed) begin
      $error("directed row disagrees with predictor: exp %h pred %h", fixed, e);
      error_count++;
    end
    pending_fusion_results.push_back(e);
    ticks_sent++;
  endtask

  // wait until idle, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_fusion_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes; caller drops it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_POS_GAIN: fz_pos_gain = val[15:0];
      REG_SPD_GAIN: fz_spd_gain = val[15:0];
      REG_SPD_GATE: fz_gate     = val;
      REG_TIMEOUT:  fz_timeout  = val[15:0];
      REG_LOST_LIM: fz_lost_lim = val[3:0];
      default: ;
    endcase
  endtask

  // random tick, mostly plausible flight data with occasional extremes
  function automatic in_item_t rand_tick(input logic [31:0] now);
    in_item_t t;
    t.func = ($urandom_range(99) < 70);
    t.sample_ready = ($urandom_range(99) < 40);
    t.alt_raw = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(8000));
    case ($urandom_range(9))
      0: t.speed_in = $urandom;
      1: t.speed_in = 32'sh7FFFFFFF;
      2: t.speed_in = 32'sh80000000;
      default: t.speed_in = $signed($urandom_range(400000)) - 200000;
    endcase
    case ($urandom_range(9))
      0: t.dt = 16'($urandom);
      1: t.dt = 16'd0;
      default: t.dt = 16'($urandom_range(1, 2000));
    endcase
    t.tick_now = ($urandom_range(19) == 0) ? $urandom : now;
    return t;
  endfunction

  initial begin
    logic [31:0] now;
    out_item_t fx;
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_data = '0;
    fuser_reset_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first tick after reset with no sample and no timeout
    fx = '0;
    directed_rows.push_back('{mk(1'b0, 1'b0, 24'd0, 32'd0, 16'd1, 32'd5), 1'b1, fx});
    // calibrate sample: offset taken, health set
    fx = '0; fx.start_conversion = 1'b1; fx.sensor_healthy = 1'b1;
    fx.speed_out = 32'sd1234;
    directed_rows.push_back('{mk(1'b0, 1'b1, 24'h000100, 32'sd1234, 16'd1, 32'd10),
                              1'b1, fx});
    add_row(mk(1'b1, 1'b1, 24'h7FFFFF, 32'sh7FFFFFFF, 16'hFFFF, 32'd20));
    add_row(mk(1'b1, 1'b1, 24'h800000, 32'sh80000000, 16'hFFFF, 32'd30));
    add_row(mk(1'b1, 1'b0, 24'h000000, 32'sd65536, 16'd0, 32'd40));
    add_row(mk(1'b1, 1'b0, 24'hFFFFFF, -32'sd65536, 16'd1, 32'd50));
    add_row(mk(1'b1, 1'b1, 24'h001000, 32'sd0, 16'd655, 32'd60));
    add_row(mk(1'b1, 1'b0, 24'h001000, 32'sd0, 16'd655, 32'd2000));   // fuse timeout
    add_row(mk(1'b1, 1'b0, 24'h001000, 32'sd100, 16'd655, 32'hFFFFFFFF));
    // calibrate timeouts counting up to the limit
    for (int i = 0; i < 11; i++)
      add_row(mk(1'b0, 1'b0, 24'h000000, 32'sd7, 16'd1, 32'd1000 + i));
    add_row(mk(1'b0, 1'b1, 24'hABCDEF, 32'sd0, 16'd1, 32'd3000));
    add_row(mk(1'b1, 1'b1, 24'h543210, 32'sd0, 16'd1000, 32'd3010));
    foreach (directed_rows[i]) send_tick(directed_rows[i].tick, directed_rows[i].has_fixed,
                                         directed_rows[i].fixed);
    drain();

    // random phases, each with its own register setting and idling mix
    now = 32'd4000;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        3: begin send_idle_pct = 17; recv_stall_pct = 17; end
        default: begin
          send_idle_pct = $urandom_range(1) * 17;
          recv_stall_pct = $urandom_range(1) * 55;
        end
      endcase
      case (phase)
        1: begin
          write_reg(REG_POS_GAIN, 32'd0);     write_reg(REG_SPD_GAIN, 32'd0);
          write_reg(REG_SPD_GATE, 32'h80000000);
          write_reg(REG_TIMEOUT, 32'd0);      write_reg(REG_LOST_LIM, 32'd1);
        end
        2: begin
          write_reg(REG_POS_GAIN, 32'hFFFF);  write_reg(REG_SPD_GAIN, 32'hFFFF);
          write_reg(REG_SPD_GATE, 32'h7FFFFFFF);
          write_reg(REG_TIMEOUT, 32'hFFFF);   write_reg(REG_LOST_LIM, 32'd15);
        end
        3: begin
          write_reg(REG_POS_GAIN, 32'd328);   write_reg(REG_SPD_GAIN, 32'd6554);
          write_reg(REG_SPD_GATE, 32'd65536); write_reg(REG_TIMEOUT, 32'd5);
          write_reg(REG_LOST_LIM, 32'd3);
        end
        default: if (phase > 3) begin
          write_reg(REG_POS_GAIN, $urandom_range(65535));
          write_reg(REG_SPD_GAIN, $urandom_range(65535));
          write_reg(REG_SPD_GATE, $urandom);
          write_reg(REG_TIMEOUT, $urandom_range(20));
          write_reg(REG_LOST_LIM, $urandom_range(1, 15));
        end
      endcase
      cfg_we <= 1'b0;
      for (int i = 0; i < 50; i++) begin
        now = now + $urandom_range(1, 8);
        send_tick(rand_tick(now), 1'b0, '0);
        // hold off until the block is empty once per phase
        if (i == 25) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_fusion_results.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("ran %0d ticks (%0d calibrate), %0d results checked, %0d speed corrections",
             ticks_sent, calib_seen, results_seen, corr_seen);
    if (error_count == 0 && pending_fusion_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
